// ----- design/rgbhsv_pkg.sv -----
`default_nettype none

package rgbhsv_pkg;

  // component width; all other widths follow from it
  localparam int CB = 12;
  // hue numerator and divisor: up to 6 * chroma, needs three extra bits
  localparam int NUM_W = CB + 3;
  // front, numerator, one stage per quotient bit, output
  localparam int NUM_STAGES = CB + 3;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CB-1:0] hue;
    logic [CB-1:0] saturation;
    logic [CB-1:0] brightness;
  } hsv_t;

  // channel holding the maximum
  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_t;

  // how saturation is formed at the output
  typedef enum logic [2:0] {
    SAT_ZERO = 3'b001,
    SAT_FULL = 3'b010,
    SAT_DIV  = 3'b100
  } sat_mode_t;

  // first stage: max, min, chroma and sector difference
  typedef struct packed {
    sector_t       sector;
    logic [CB-1:0] vmax;
    logic [CB-1:0] vmin;
    logic [CB-1:0] chroma;
    logic [CB:0]   diff;
  } front_t;

  // divider stages: two restoring dividers side by side
  typedef struct packed {
    logic             hue_neg;
    logic             hue_zero;
    logic [NUM_W-1:0] hue_rem;
    logic [NUM_W-1:0] hue_div;
    logic [CB-1:0]    hue_q;
    sat_mode_t        sat_mode;
    logic [CB-1:0]    sat_rem;
    logic [CB-1:0]    sat_div;
    logic [CB-1:0]    sat_q;
    logic [CB-1:0]    brightness;
  } div_t;

  // one quotient bit of both dividers; remainder stays below divisor
  function automatic div_t div_step(div_t s);
    div_t         n;
    logic [NUM_W:0] ht;
    logic [CB:0]    st;
    n  = s;
    ht = {s.hue_rem, 1'b0};
    st = {s.sat_rem, 1'b0};
    if (ht >= {1'b0, s.hue_div}) begin
      n.hue_rem = NUM_W'(ht - {1'b0, s.hue_div});
      n.hue_q   = {s.hue_q[CB-2:0], 1'b1};
    end else begin
      n.hue_rem = ht[NUM_W-1:0];
      n.hue_q   = {s.hue_q[CB-2:0], 1'b0};
    end
    if (st >= {1'b0, s.sat_div}) begin
      n.sat_rem = CB'(st - {1'b0, s.sat_div});
      n.sat_q   = {s.sat_q[CB-2:0], 1'b1};
    end else begin
      n.sat_rem = st[CB-1:0];
      n.sat_q   = {s.sat_q[CB-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- design/rgb_to_hsv_converter.sv -----
// RGB to HSV pixel converter.
//
// Input channel: pixel (red, green, blue) with pixel_valid / pixel_stall.
// Output channel: hsv (hue, saturation, brightness) with hsv_valid / hsv_stall.
// A transfer happens on a rising edge with valid high and stall low.
// All fields are unsigned fractions of full scale, CB bits each.
//
// Throughput: one pixel per clock, with no gaps, while pixel_stall stays low.
// Depth: CB + 3 register stages (15 at 12 bits). The depth comes from the two
// restoring dividers (saturation and hue), one quotient bit per stage.
//
// Each stage holds a valid bit and moves on when the next stage is empty or
// moving. When the receiver stalls, the output register holds its result and
// the stages behind it keep filling bubbles; pixel_stall rises only once
// every stage holds a pixel. Nothing is lost or repeated.
//
// Reset (rst, synchronous) clears all valid bits; the pipeline is empty and
// ready on the first cycle after reset.
`default_nettype none

module rgb_to_hsv_converter (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pixel_valid,
  output logic                     pixel_stall,
  input  wire rgbhsv_pkg::pixel_t  pixel,
  output logic                     hsv_valid,
  input  wire logic                hsv_stall,
  output rgbhsv_pkg::hsv_t         hsv
);

  localparam int CB    = rgbhsv_pkg::CB;
  localparam int NUM_W = rgbhsv_pkg::NUM_W;
  localparam int NST   = rgbhsv_pkg::NUM_STAGES;
  localparam int LAST  = rgbhsv_pkg::NUM_STAGES - 1;

  // valid bit and advance enable per stage
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  rgbhsv_pkg::front_t front, front_next;
  rgbhsv_pkg::div_t   numer, numer_next;
  rgbhsv_pkg::div_t   dstg [CB];
  rgbhsv_pkg::hsv_t   hsv_next;

  // advance chain from the output back to the input
  assign adv[LAST] = !vld[LAST] || !hsv_stall;
  genvar gi;
  generate
    for (gi = 0; gi < LAST; gi++) begin : g_adv
      assign adv[gi] = !vld[gi] || adv[gi+1];
    end
  endgenerate

  assign pixel_stall = !adv[0];
  assign hsv_valid   = vld[LAST];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pixel_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // front: max with red, green, blue priority, min, chroma, difference
  always_comb begin
    logic [CB-1:0] r, g, b, mn;
    r  = pixel.red;
    g  = pixel.green;
    b  = pixel.blue;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    front_next = '0;
    if (r >= g && r >= b) begin
      front_next.sector = rgbhsv_pkg::SEC_RED;
      front_next.vmax   = r;
      front_next.diff   = {1'b0, g} - {1'b0, b};
    end else if (g >= b) begin
      front_next.sector = rgbhsv_pkg::SEC_GREEN;
      front_next.vmax   = g;
      front_next.diff   = {1'b0, b} - {1'b0, r};
    end else begin
      front_next.sector = rgbhsv_pkg::SEC_BLUE;
      front_next.vmax   = b;
      front_next.diff   = {1'b0, r} - {1'b0, g};
    end
    front_next.vmin   = mn;
    front_next.chroma = front_next.vmax - mn;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      front <= front_next;
    end
  end

  // hue numerator, divisor 6 * chroma, saturation mode
  always_comb begin
    logic [NUM_W:0] offset;
    logic [NUM_W:0] num;
    offset = '0;
    unique case (front.sector)
      rgbhsv_pkg::SEC_RED:   offset = '0;
      rgbhsv_pkg::SEC_GREEN: offset = (NUM_W+1)'({front.chroma, 1'b0});
      rgbhsv_pkg::SEC_BLUE:  offset = (NUM_W+1)'({front.chroma, 2'b0});
      default:               offset = '0;
    endcase
    num = offset + {{(NUM_W-CB){front.diff[CB]}}, front.diff};
    numer_next            = '0;
    numer_next.hue_neg    = num[NUM_W];
    numer_next.hue_zero   = (front.chroma == '0);
    numer_next.hue_rem    = num[NUM_W] ? NUM_W'(-num) : num[NUM_W-1:0];
    numer_next.hue_div    = NUM_W'({front.chroma, 2'b0}) + NUM_W'({front.chroma, 1'b0});
    numer_next.sat_rem    = front.chroma;
    numer_next.sat_div    = front.vmax;
    numer_next.brightness = front.vmax;
    if (front.vmax == '0) begin
      numer_next.sat_mode = rgbhsv_pkg::SAT_ZERO;
    end else if (front.vmin == '0) begin
      numer_next.sat_mode = rgbhsv_pkg::SAT_FULL;
    end else begin
      numer_next.sat_mode = rgbhsv_pkg::SAT_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      numer <= numer_next;
    end
  end

  // divider stages, one quotient bit each
  generate
    for (gi = 0; gi < CB; gi++) begin : g_div
      if (gi == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv[2]) begin
            dstg[0] <= rgbhsv_pkg::div_step(numer);
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (adv[gi+2]) begin
            dstg[gi] <= rgbhsv_pkg::div_step(dstg[gi-1]);
          end
        end
      end
    end
  endgenerate

  // output: sign and wrap of hue, saturation select
  always_comb begin
    rgbhsv_pkg::div_t d;
    d = dstg[CB-1];
    hsv_next.brightness = d.brightness;
    if (d.hue_zero) begin
      hsv_next.hue = '0;
    end else if (d.hue_neg) begin
      hsv_next.hue = {CB{1'b0}} - d.hue_q;
    end else begin
      hsv_next.hue = d.hue_q;
    end
    unique case (d.sat_mode)
      rgbhsv_pkg::SAT_ZERO: hsv_next.saturation = '0;
      rgbhsv_pkg::SAT_FULL: hsv_next.saturation = '1;
      rgbhsv_pkg::SAT_DIV:  hsv_next.saturation = d.sat_q;
      default:              hsv_next.saturation = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      hsv <= hsv_next;
    end
  end

`ifndef SYNTH
  // zero saturation means a gray pixel, whose hue is zero
  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hsv.saturation != '0 || hsv.hue == '0))
    else $error("nonzero hue on gray pixel");

  // input stalls only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (&vld))
    else $error("input stalled with a free stage");

  // hue remainder stays below its divisor at the end of the divider
  a_hue_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST-1] && !dstg[CB-1].hue_zero) |-> (dstg[CB-1].hue_rem < dstg[CB-1].hue_div))
    else $error("hue remainder out of range");

  // saturation remainder stays below brightness when dividing
  a_sat_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST-1] && dstg[CB-1].sat_mode == rgbhsv_pkg::SAT_DIV)
      |-> (dstg[CB-1].sat_rem < dstg[CB-1].sat_div))
    else $error("saturation remainder out of range");
`endif

endmodule

`default_nettype wire

// ----- sim/rgb_to_hsv_converter_tb.sv -----
`timescale 1ns / 100ps

module rgb_to_hsv_converter_tb;
  import rgbhsv_pkg::*;

  localparam longint FULL_SCALE = longint'(1) << CB;
  localparam int CYCLE_LIMIT = 500000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_stall;
  pixel_t pixel = '0;
  logic   hsv_valid;
  logic   hsv_stall = 1'b0;
  hsv_t   hsv;

  // queue of hsv results still owed by the pipeline
  hsv_t expected_hsv[$];

  int  error_count = 0;
  int  pixels_sent = 0;
  int  results_checked = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;
  bit  stall_on = 1'b1;
  bit  force_stall = 1'b0;

  rgb_to_hsv_converter i_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hsv         (hsv)
  );

  always #2 clk = ~clk;

  // fixed-point rgb to hsv, quotients truncated toward zero
  function automatic hsv_t convert_pixel(pixel_t p);
    longint r, g, b, vmax, vmin, chroma, num, h, s;
    hsv_t   res;
    r = longint'(p.red);
    g = longint'(p.green);
    b = longint'(p.blue);
    vmax = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    vmin = r;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    chroma = vmax - vmin;
    s = 0;
    h = 0;
    // black pixel keeps zero saturation; min of zero clips to full scale
    if (vmax != 0) begin
      s = (chroma * FULL_SCALE) / vmax;
      if (s > FULL_SCALE - 1) s = FULL_SCALE - 1;
    end
    // gray pixel keeps zero hue; ties go red, then green, then blue
    if (chroma != 0) begin
      if (vmax == r) num = g - b;
      else if (vmax == g) num = 2 * chroma + (b - r);
      else num = 4 * chroma + (r - g);
      h = (num * FULL_SCALE) / (6 * chroma);
      if (h < 0) h += FULL_SCALE;
    end
    res.hue        = CB'(h);
    res.saturation = CB'(s);
    res.brightness = CB'(vmax);
    return res;
  endfunction

  function automatic pixel_t make_pixel(int r, int g, int b);
    pixel_t p;
    p.red   = CB'(r);
    p.green = CB'(g);
    p.blue  = CB'(b);
    return p;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int pause_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 8);
    return $urandom_range(9, 30);
  endfunction

  function automatic logic [CB-1:0] corner_component();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CB'(1);
      2: return {CB{1'b1}} - 1'b1;
      3: return {CB{1'b1}};
      default: return CB'($urandom);
    endcase
  endfunction

  // random pixel leaning on ties, grays, corners and small chroma
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     hi, lo, base, which;
    p.red   = CB'($urandom);
    p.green = CB'($urandom);
    p.blue  = CB'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        p.red   = CB'($urandom);
        p.green = p.red;
        p.blue  = p.red;
      end
      1: begin
        hi = $urandom_range(1, int'(FULL_SCALE - 1));
        lo = $urandom_range(0, hi - 1);
        which = $urandom_range(0, 2);
        p = make_pixel(which == 2 ? lo : hi, which == 1 ? lo : hi, which == 0 ? lo : hi);
      end
      2: begin
        p.red   = corner_component();
        p.green = corner_component();
        p.blue  = corner_component();
      end
      3: begin
        base = $urandom_range(4, int'(FULL_SCALE - 5));
        p = make_pixel(base + $urandom_range(0, 4) - 2, base + $urandom_range(0, 4) - 2,
                       base + $urandom_range(0, 4) - 2);
      end
      default: ;
    endcase
    return p;
  endfunction

  // one pixel transfer, then an optional idle gap
  task automatic send_pixel(pixel_t p);
    int gap;
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    expected_hsv.push_back(convert_pixel(p));
    pixels_sent++;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 30) gap = pause_length();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    while (expected_hsv.size() != 0) @(posedge clk);
  endtask

  // extremes, every sector and the named special cases
  task automatic test_directed_cases();
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(4095, 4095, 4095));
    send_pixel(make_pixel(2048, 2048, 2048));
    send_pixel(make_pixel(4095, 0, 0));
    send_pixel(make_pixel(0, 4095, 0));
    send_pixel(make_pixel(0, 0, 4095));
    send_pixel(make_pixel(4095, 4095, 0));
    send_pixel(make_pixel(0, 4095, 4095));
    send_pixel(make_pixel(4095, 0, 4095));
    send_pixel(make_pixel(4095, 0, 1));
    send_pixel(make_pixel(4095, 0, 100));
    send_pixel(make_pixel(3000, 1000, 2999));
    send_pixel(make_pixel(1000, 3000, 2000));
    send_pixel(make_pixel(1000, 2000, 3000));
    send_pixel(make_pixel(4095, 4094, 4094));
    send_pixel(make_pixel(1, 0, 0));
    send_pixel(make_pixel(0, 1, 0));
    send_pixel(make_pixel(0, 0, 1));
    send_pixel(make_pixel(1, 1, 0));
    send_pixel(make_pixel('haaa, 'h555, 'haaa));
    send_pixel(make_pixel('h555, 'haaa, 'h555));
    send_pixel(make_pixel(4095, 1, 4095));
    wait_drained();
  endtask

  // random stream; gaps and stalls switch on and off per burst
  task automatic test_random_stream(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        stall_on <= ($urandom_range(0, 3) != 0);
      end
      send_pixel(random_pixel());
    end
    gaps_on = 1'b1;
    stall_on <= 1'b1;
  endtask

  // receiver held off long enough for the whole pipeline to fill
  task automatic test_full_backpressure();
    gaps_on = 1'b0;
    force_stall <= 1'b1;
    fork
      begin
        repeat (40) send_pixel(random_pixel());
      end
      begin
        repeat (45) @(posedge clk);
        force_stall <= 1'b0;
      end
    join
    gaps_on = 1'b1;
  endtask

  // sender pauses until everything in flight has come out
  task automatic test_drain_pause();
    repeat (50) send_pixel(random_pixel());
    wait_drained();
    repeat (50) send_pixel(random_pixel());
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    int stall_left;
    if (rst) begin
      stall_left = 0;
      hsv_stall <= 1'b0;
    end else if (force_stall) begin
      hsv_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      hsv_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 99) < 25) begin
      stall_left = pause_length() - 1;
      hsv_stall <= 1'b1;
    end else begin
      hsv_stall <= 1'b0;
    end
  end

  // compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    hsv_t want;
    if (!rst && hsv_valid && !hsv_stall) begin
      if (expected_hsv.size() == 0) begin
        $error("unexpected result: hue %0d saturation %0d brightness %0d",
               hsv.hue, hsv.saturation, hsv.brightness);
        error_count++;
      end else begin
        want = expected_hsv.pop_front();
        results_checked++;
        if (hsv.hue !== want.hue) begin
          $error("hue: expected %0d, actual %0d", want.hue, hsv.hue);
          error_count++;
        end
        if (hsv.saturation !== want.saturation) begin
          $error("saturation: expected %0d, actual %0d", want.saturation, hsv.saturation);
          error_count++;
        end
        if (hsv.brightness !== want.brightness) begin
          $error("brightness: expected %0d, actual %0d", want.brightness, hsv.brightness);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_hsv.size());
      $display("rgb_to_hsv_converter_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_backpressure();
    test_random_stream(600);
    test_drain_pause();
    test_random_stream(500);
    wait_drained();
    repeat (NUM_STAGES + 10) @(posedge clk);
    $display("sent %0d pixels, checked %0d results", pixels_sent, results_checked);
    $display("covered black, gray, ties, hue wrap, full saturation, backpressure and drain");
    if (error_count == 0) begin
      $display("rgb_to_hsv_converter_tb: clean");
    end else begin
      $display("rgb_to_hsv_converter_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rgbhsv_pkg.sv
design/rgb_to_hsv_converter.sv
sim/rgb_to_hsv_converter_tb.sv
